### sv/brsrc_pkg.sv
// Shared constants, operation codes and word helpers for the bitmap range block.
// No dependencies; compile first.
package brsrc_pkg;

    localparam int WORD_BITS     = 64;
    localparam int DEFAULT_WORDS = 64;
    localparam int START_W       = 12;
    localparam int LEN_W         = 13;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Count of consecutive ones from bit 0, 0..64, by halving search.
    function automatic logic [6:0] trailing_ones(input logic [63:0] v);
        logic [63:0] z;
        logic [6:0]  n;
        z = ~v;
        n = 7'd0;
        if (z == 64'd0) begin
            n = 7'd64;
        end else begin
            if (z[31:0] == 32'd0) begin
                n = n + 7'd32;
                z = z >> 32;
            end
            if (z[15:0] == 16'd0) begin
                n = n + 7'd16;
                z = z >> 16;
            end
            if (z[7:0] == 8'd0) begin
                n = n + 7'd8;
                z = z >> 8;
            end
            if (z[3:0] == 4'd0) begin
                n = n + 7'd4;
                z = z >> 4;
            end
            if (z[1:0] == 2'd0) begin
                n = n + 7'd2;
                z = z >> 2;
            end
            if (z[0] == 1'b0) begin
                n = n + 7'd1;
            end
        end
        return n;
    endfunction

    // Ones in bit positions [lo, hi) of a word, lo < hi <= 64.
    function automatic logic [63:0] span_mask(input logic [5:0] lo, input logic [6:0] hi);
        logic [63:0] upper;
        logic [63:0] lower;
        upper = hi[6] ? {64{1'b1}} : ((64'd1 << hi[5:0]) - 64'd1);
        lower = (64'd1 << lo) - 64'd1;
        return upper & ~lower;
    endfunction

endpackage

### sv/brsrc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on brsrc_pkg for field widths.
interface brsrc_req_if
    import brsrc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [START_W-1:0] start_bit;
    logic [LEN_W-1:0]   length;

    modport source (output valid, output operation, output start_bit, output length,
                    input ready);
    modport sink   (input valid, input operation, input start_bit, input length,
                    output ready);
endinterface

interface brsrc_rsp_if
    import brsrc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] run_length;

    modport source (output valid, output run_length, input ready);
    modport sink   (input valid, input run_length, output ready);
endinterface

### sv/brsrc_ram.sv
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module brsrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/bitmap_range_set_and_run_check.sv
// Allocation bitmap with range set and run-of-ones check.
// Depends on brsrc_pkg, brsrc_if (brsrc_req_if, brsrc_rsp_if) and brsrc_ram.
//
// Usage: req carries one request per beat (operation, start_bit, length);
// rsp returns exactly one beat per request. A set ORs ones into the bits
// [start_bit, start_bit+length), clipped at the store end, and answers 0.
// A check answers min(length, run of ones from start_bit), stopping at the
// store end.
// The bitmap is WORDS words of 64 bits in one RAM; a set gives each touched
// word one read-modify-write, a check only reads the words it scans. A request
// passes the idle, read, work and done states, the work state handling the
// touched words (1..WORDS) in turn; empty ranges skip the work state. The
// result beat is loaded from the done state once the output register is free.
// One request is in flight at a time; req.ready is high whenever the
// sequencer is idle, even while a result is still held in the output register.
// Reset: a clearing pass writes zero to every word, one word a cycle;
// req.ready stays low until it ends.
// A stalled receiver holds the result in the output register; a finished
// request then waits until that register frees up.
module bitmap_range_set_and_run_check
    import brsrc_pkg::*;
#(
    parameter int WORDS = DEFAULT_WORDS
) (
    input  logic clk,
    input  logic rst_n,
    brsrc_req_if.sink   req,
    brsrc_rsp_if.source rsp
);

    localparam int TOTAL  = WORDS * WORD_BITS;
    localparam int PW     = ($clog2(TOTAL) + 1 > 14) ? $clog2(TOTAL) + 1 : 14;
    localparam int WIDX_W = PW - 6;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RUN_W  = LEN_W + 1;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WORK, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               op_reg, op_next;
    logic [START_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PW-1:0]      end_reg, end_next;
    logic [WIDX_W-1:0]  first_reg, first_next;
    logic [WIDX_W-1:0]  w_reg, w_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic [LEN_W-1:0]   res_reg, res_next;
    logic [LEN_W-1:0]   out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [PW-1:0]      sum_in;
    logic [PW-1:0]      end_m1;
    logic [WIDX_W-1:0]  last_w;
    logic [WIDX_W-1:0]  w_inc;
    logic               range_empty;
    logic [5:0]         bit_off;
    logic [6:0]         hi_pos;
    logic [6:0]         avail;
    logic [6:0]         ones;
    logic [RUN_W-1:0]   run_sum;
    logic [LEN_W-1:0]   run_min;
    logic               at_top_word;
    logic               check_done;

    brsrc_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS),
        .AW   (AW)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.run_length = out_reg;

    // Word-level arithmetic for the word now on the RAM read port.
    always_comb
    begin
        sum_in      = PW'(req.start_bit) + PW'(req.length);
        end_m1      = end_reg - PW'(1);
        last_w      = WIDX_W'(end_m1 >> 6);
        w_inc       = w_reg + WIDX_W'(1);
        range_empty = (PW'(start_reg) >= end_reg);
        bit_off     = (w_reg == first_reg) ? start_reg[5:0] : 6'd0;
        hi_pos      = (w_reg == last_w) ? (7'(end_m1[5:0]) + 7'd1) : 7'd64;
        avail       = 7'd64 - 7'(bit_off);
        ones        = trailing_ones(ram_rdata >> bit_off);
        run_sum     = run_reg + RUN_W'(ones);
        run_min     = (run_sum >= RUN_W'(len_reg)) ? len_reg : run_sum[LEN_W-1:0];
        at_top_word = (w_reg == WIDX_W'(WORDS - 1));
        check_done  = (ones != avail) || (run_sum >= RUN_W'(len_reg)) || at_top_word;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        end_next       = end_reg;
        first_next     = first_reg;
        w_next         = w_reg;
        run_next       = run_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = w_reg[AW-1:0];
        ram_wdata = ram_rdata | span_mask(bit_off, hi_pos);
        ram_raddr = w_inc[AW-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    start_next = req.start_bit;
                    len_next   = req.length;
                    end_next   = (sum_in > PW'(TOTAL)) ? PW'(TOTAL) : sum_in;
                    first_next = WIDX_W'(req.start_bit[START_W-1:6]);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // Issue the first word's read; empty ranges answer at once.
                ram_raddr = first_reg[AW-1:0];
                w_next    = first_reg;
                run_next  = '0;
                if (range_empty)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                // Next word's read goes out while this word is processed.
                w_next = w_inc;
                if (op_reg == OP_SET)
                begin
                    ram_we = 1'b1;
                    if (w_reg == last_w)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    run_next = run_sum;
                    if (check_done)
                    begin
                        res_next   = run_min;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            op_reg        <= OP_SET;
            start_reg     <= '0;
            len_reg       <= '0;
            end_reg       <= '0;
            first_reg     <= '0;
            w_reg         <= '0;
            run_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            op_reg        <= op_next;
            start_reg     <= start_next;
            len_reg       <= len_next;
            end_reg       <= end_next;
            first_reg     <= first_next;
            w_reg         <= w_next;
            run_reg       <= run_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Store writes come only from the clearing pass or a set's word update.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR) || (state_reg == S_WORK && op_reg == OP_SET))
        else $error("store written outside clear pass or set update");

    // The word being worked on always lies inside the store.
    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORK) |-> (w_reg <= WIDX_W'(WORDS - 1)))
        else $error("word index beyond store");

    // A result beat appears only as a request finishes.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    // A set always answers zero.
    a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && op_reg == OP_SET) |-> (res_reg == '0))
        else $error("set produced non-zero result");

endmodule
